// File: rtl/bblur_pkg.sv
// Shared types, constants and the reciprocal table for the 3x3 box blur.
// No dependencies; every other file in rtl/ depends on this package.
`timescale 1ns / 1ps
`default_nettype none

package bblur_pkg;

   localparam int DEF_MAX_WIDTH = 1024;

   localparam logic [10:0] RESET_IMAGE_WIDTH  = 11'd1024;
   localparam logic [15:0] RESET_IMAGE_HEIGHT = 16'd768;

   // csr register indexes
   localparam logic [0:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [0:0] CSR_IMAGE_HEIGHT = 1'b1;

   // request operation codes
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // reciprocal scale: quotient = ((2*sum + cnt) * recip(cnt)) >> RECIP_SHIFT
   localparam int RECIP_SHIFT = 20;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_STEP,
      ST_MUL
   } state_type;

   // vertical sum of one column (up to three rows), channel 2 = red
   typedef struct packed {
      logic [2:0][9:0] sum;
      logic [1:0]      cnt;
      logic            vld;
   } colsum_type;

   // neighborhood totals handed to the divider
   typedef struct packed {
      logic [2:0][11:0] sum;
      logic [3:0]       cnt;
      logic             last;
   } emit_type;

   // per-step control from the sequencer to the window
   typedef struct packed {
      logic step;
      logic col_zero;
      logic row_ge1;
      logic row_ge2;
      logic has_px;
      logic restart;
   } step_ctrl_type;

   // ceil(2^20 / (2*cnt)); exact for numerators below 2^13
   function automatic logic [19:0] recip(input logic [3:0] cnt);
      logic [19:0] r;
      case (cnt)
         4'd1:    r = 20'd524288;
         4'd2:    r = 20'd262144;
         4'd3:    r = 20'd174763;
         4'd4:    r = 20'd131072;
         4'd5:    r = 20'd104858;
         4'd6:    r = 20'd87382;
         4'd7:    r = 20'd74899;
         4'd8:    r = 20'd65536;
         4'd9:    r = 20'd58255;
         default: r = 20'd0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/bblur_row_mem.sv
// One row store: 24-bit pixels, one write port, one registered read port.
// Depends on bblur_pkg for the default depth.
`timescale 1ns / 1ps
`default_nettype none

module bblur_row_mem #(
   parameter int  DEPTH = bblur_pkg::DEF_MAX_WIDTH,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [23:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [23:0]   rd_data
);

   logic [23:0] mem [DEPTH];
   logic [23:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/bblur_window.sv
// Column-sum window: builds the new column sum from the row store reads,
// forms the neighborhood totals and shifts the two-column window.
// Depends on bblur_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bblur_window (
   input  logic                     clock,
   input  logic                     reset,
   input  bblur_pkg::step_ctrl_type ctrl,
   input  logic [23:0]              px,
   input  logic [23:0]              above_q,
   input  logic [23:0]              current_q,
   output bblur_pkg::emit_type      emit
);
   import bblur_pkg::*;

   colsum_type win_a_ff, win_a_in;
   colsum_type win_b_ff, win_b_in;
   colsum_type nw;
   emit_type   emit_ff, emit_in;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         nw.sum[ch] = (ctrl.row_ge2 ? {2'b00, above_q[8*ch +: 8]}   : 10'd0)
                    + (ctrl.row_ge1 ? {2'b00, current_q[8*ch +: 8]} : 10'd0)
                    + (ctrl.has_px  ? {2'b00, px[8*ch +: 8]}        : 10'd0);
      end
      nw.cnt = {1'b0, ctrl.row_ge2} + {1'b0, ctrl.row_ge1} + {1'b0, ctrl.has_px};
      nw.vld = 1'b1;
   end

   // totals: left and middle if valid, right only away from column zero
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         emit_in.sum[ch] = (win_a_ff.vld ? 12'(win_a_ff.sum[ch]) : 12'd0)
                         + (win_b_ff.vld ? 12'(win_b_ff.sum[ch]) : 12'd0)
                         + (!ctrl.col_zero ? 12'(nw.sum[ch]) : 12'd0);
      end
      emit_in.cnt  = (win_a_ff.vld ? 4'(win_a_ff.cnt) : 4'd0)
                   + (win_b_ff.vld ? 4'(win_b_ff.cnt) : 4'd0)
                   + (!ctrl.col_zero ? 4'(nw.cnt) : 4'd0);
      emit_in.last = ctrl.restart;
   end

   always_comb begin
      win_a_in = win_a_ff;
      win_b_in = win_b_ff;
      if (ctrl.step) begin
         if (ctrl.restart) begin
            win_a_in = '0;
            win_b_in = '0;
         end else if (ctrl.col_zero) begin
            win_a_in.vld = 1'b0;
            win_b_in     = nw;
         end else begin
            win_a_in = win_b_ff;
            win_b_in = nw;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_a_ff <= '0;
         win_b_ff <= '0;
      end else begin
         win_a_ff <= win_a_in;
         win_b_ff <= win_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.step) begin
         emit_ff <= emit_in;
      end
   end

   assign emit = emit_ff;

endmodule

`default_nettype wire

// File: rtl/bblur_div.sv
// Rounded average by reciprocal multiply, and the response output register.
// Depends on bblur_pkg for emit_type and the reciprocal table.
`timescale 1ns / 1ps
`default_nettype none

module bblur_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  bblur_pkg::emit_type emit,
   input  logic                rsp_ready,
   output logic                free,
   output logic                rsp_valid,
   output logic [7:0]          rsp_out_red,
   output logic [7:0]          rsp_out_green,
   output logic [7:0]          rsp_out_blue,
   output logic                rsp_last
);
   import bblur_pkg::*;

   logic [19:0]      recip_val;
   logic [2:0][12:0] numer;
   logic [2:0][32:0] prod;
   logic [2:0][7:0]  quot;

   logic             valid_ff, valid_in;
   logic [2:0][7:0]  quot_ff;
   logic             last_ff;

   // (2*sum + cnt) / (2*cnt): round half up
   always_comb begin
      recip_val = recip(emit.cnt);
      for (int ch = 0; ch < 3; ch++) begin
         numer[ch] = {emit.sum[ch], 1'b0} + 13'(emit.cnt);
         prod[ch]  = {20'd0, numer[ch]} * {13'd0, recip_val};
         quot[ch]  = prod[ch][RECIP_SHIFT +: 8];
      end
   end

   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         quot_ff <= quot;
         last_ff <= emit.last;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_red   = quot_ff[2];
   assign rsp_out_green = quot_ff[1];
   assign rsp_out_blue  = quot_ff[0];
   assign rsp_last      = last_ff;

endmodule

`default_nettype wire

// File: rtl/box_blur_3x3_edge_clipped_top.sv
// Top level of the edge-clipped 3x3 box blur: sequencer, config registers,
// two row stores, the column-sum window and the divider.
// Depends on bblur_pkg, bblur_row_mem, bblur_window, bblur_div.
//
//   channel | direction | beat fields                            | handshake
//   req     | in        | operation, red, green, blue            | req_valid / req_ready
//   rsp     | out       | out_red, out_green, out_blue, last     | rsp_valid / rsp_ready
//   csr     | in        | index (0 width, 1 height), wdata[15:0] | csr_we, no wait
//
// A beat that yields a result passes through reading the row stores, update and
// sum, and the reciprocal multiply; a pixel with no result skips the multiply,
// and a drain beat mid-image is dropped in idle. An empty drain slot on a
// one-row image goes straight on to read the next column before idle.
// After reset a clearing pass zeroes all MAX_WIDTH entries (1024 by default)
// of both row stores with req_ready low; csr writes are taken throughout.
// A stalled rsp beat holds the next result in the multiply stage, and
// req_ready stays low until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module box_blur_3x3_edge_clipped_top #(
   parameter int MAX_WIDTH = bblur_pkg::DEF_MAX_WIDTH
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_blue,
   output logic        rsp_last,

   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import bblur_pkg::*;

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int EW = $clog2(MAX_WIDTH + 1);
   localparam logic [CW-1:0] CLEAR_LAST = CW'(MAX_WIDTH - 1);

   state_type     state_ff, state_in;
   logic [10:0]   width_ff, width_in;
   logic [15:0]   height_ff, height_in;
   logic [15:0]   row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [EW-1:0] drain_ff, drain_in;
   logic [CW-1:0] clear_ff, clear_in;
   logic [23:0]   px_ff, px_in;
   logic [CW-1:0] stp_col_ff, stp_col_in;
   logic          r_ge1_ff, r_ge1_in;
   logic          r_ge2_ff, r_ge2_in;
   logic          has_px_ff, has_px_in;
   logic          last_step_ff, last_step_in;

   logic [EW-1:0] eff_w;
   logic [15:0]   eff_h;
   logic          pixel_mode;
   logic          accept;
   logic          drop_item;
   logic          row_ge1;
   logic          row_ge2;
   logic          col_zero;
   logic          emit_k;
   logic [EW-1:0] nxt_d;
   logic          loop_again;
   logic          launch;
   logic          launch_pixel;
   logic [EW-1:0] ld_d;
   logic          ld_d_in_row;
   logic          out_free;
   logic          div_load;

   logic          rd_en;
   logic [CW-1:0] rd_addr;
   logic          wr_en;
   logic [CW-1:0] wr_addr;
   logic [23:0]   above_wdata;
   logic [23:0]   current_wdata;
   logic [23:0]   above_q;
   logic [23:0]   current_q;

   step_ctrl_type ctrl;
   emit_type      emit;

   // effective geometry
   always_comb begin
      if (width_ff == 11'd0) begin
         eff_w = EW'(1);
      end else if ({5'd0, width_ff} > 16'(MAX_WIDTH)) begin
         eff_w = EW'(MAX_WIDTH);
      end else begin
         eff_w = EW'(width_ff);
      end
      eff_h = (height_ff == 16'd0) ? 16'd1 : height_ff;
   end

   assign pixel_mode  = row_ff < eff_h;
   assign accept      = req_valid && req_ready;
   assign drop_item   = pixel_mode && (req_operation == OP_DRAIN);
   assign row_ge1     = row_ff != 16'd0;
   assign row_ge2     = row_ff >= 16'd2;
   assign col_zero    = stp_col_ff == '0;
   assign emit_k      = col_zero ? r_ge2_ff : r_ge1_ff;
   assign nxt_d       = drain_ff + EW'(1);
   // a drain slot without output moves straight on to the next column
   assign loop_again  = (state_ff == ST_STEP) && !emit_k && !has_px_ff && !last_step_ff;
   assign launch_pixel = (state_ff == ST_IDLE) && accept && pixel_mode && !drop_item;
   assign launch      = ((state_ff == ST_IDLE) && accept && !drop_item) || loop_again;
   assign ld_d        = (state_ff == ST_STEP) ? nxt_d : drain_ff;
   assign ld_d_in_row = ld_d < eff_w;
   assign div_load    = (state_ff == ST_MUL) && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clear_ff == CLEAR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && !drop_item) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (emit_k) begin
               state_in = ST_MUL;
            end else if (!loop_again) begin
               state_in = ST_IDLE;
            end
         end
         ST_MUL: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready = state_ff == ST_IDLE;

      rd_en = launch;
      if (launch_pixel) begin
         rd_addr = col_ff;
      end else if (ld_d_in_row) begin
         rd_addr = ld_d[CW-1:0];
      end else begin
         rd_addr = '0;
      end

      if (state_ff == ST_CLEAR) begin
         wr_en         = 1'b1;
         wr_addr       = clear_ff;
         above_wdata   = 24'd0;
         current_wdata = 24'd0;
      end else begin
         wr_en         = (state_ff == ST_STEP) && has_px_ff;
         wr_addr       = stp_col_ff;
         above_wdata   = current_q;
         current_wdata = px_ff;
      end

      ctrl.step     = state_ff == ST_STEP;
      ctrl.col_zero = col_zero;
      ctrl.row_ge1  = r_ge1_ff;
      ctrl.row_ge2  = r_ge2_ff;
      ctrl.has_px   = has_px_ff;
      ctrl.restart  = last_step_ff;
   end

   // register next values
   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      drain_in     = drain_ff;
      clear_in     = clear_ff;
      px_in        = px_ff;
      stp_col_in   = stp_col_ff;
      r_ge1_in     = r_ge1_ff;
      r_ge2_in     = r_ge2_ff;
      has_px_in    = has_px_ff;
      last_step_in = last_step_ff;

      if (state_ff == ST_CLEAR) begin
         clear_in = clear_ff + CW'(1);
      end

      if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata[10:0];
            CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end

      if (launch) begin
         if (launch_pixel) begin
            px_in        = {req_red, req_green, req_blue};
            stp_col_in   = col_ff;
            r_ge1_in     = row_ge1;
            r_ge2_in     = row_ge2;
            has_px_in    = 1'b1;
            last_step_in = 1'b0;
         end else if (ld_d_in_row) begin
            stp_col_in   = ld_d[CW-1:0];
            r_ge1_in     = row_ge1;
            r_ge2_in     = row_ge2;
            has_px_in    = 1'b0;
            last_step_in = 1'b0;
         end else begin
            // closing step: row one past the image, column zero
            stp_col_in   = '0;
            r_ge1_in     = 1'b1;
            r_ge2_in     = row_ge1;
            has_px_in    = 1'b0;
            last_step_in = 1'b1;
         end
      end

      if (state_ff == ST_STEP) begin
         if (has_px_ff) begin
            if (EW'(col_ff) + EW'(1) >= eff_w) begin
               col_in = '0;
               row_in = row_ff + 16'd1;
            end else begin
               col_in = col_ff + CW'(1);
            end
         end else if (last_step_ff) begin
            row_in   = 16'd0;
            col_in   = '0;
            drain_in = '0;
         end else begin
            drain_in = nxt_d;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         width_ff     <= RESET_IMAGE_WIDTH;
         height_ff    <= RESET_IMAGE_HEIGHT;
         row_ff       <= 16'd0;
         col_ff       <= '0;
         drain_ff     <= '0;
         clear_ff     <= '0;
         stp_col_ff   <= '0;
         r_ge1_ff     <= 1'b0;
         r_ge2_ff     <= 1'b0;
         has_px_ff    <= 1'b0;
         last_step_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         drain_ff     <= drain_in;
         clear_ff     <= clear_in;
         stp_col_ff   <= stp_col_in;
         r_ge1_ff     <= r_ge1_in;
         r_ge2_ff     <= r_ge2_in;
         has_px_ff    <= has_px_in;
         last_step_ff <= last_step_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff <= px_in;
   end

   bblur_row_mem #(
      .DEPTH(MAX_WIDTH)
   ) u_above (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (above_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (above_q)
   );

   bblur_row_mem #(
      .DEPTH(MAX_WIDTH)
   ) u_current (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (current_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (current_q)
   );

   bblur_window u_window (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .px        (px_ff),
      .above_q   (above_q),
      .current_q (current_q),
      .emit      (emit)
   );

   bblur_div u_div (
      .clock         (clock),
      .reset         (reset),
      .load          (div_load),
      .emit          (emit),
      .rsp_ready     (rsp_ready),
      .free          (out_free),
      .rsp_valid     (rsp_valid),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_last      (rsp_last)
   );

endmodule

`default_nettype wire

// File: rtl/bblur_checker.sv
// Port-level checks for the box blur top, bound to every instance.
// Depends on bblur_pkg and box_blur_3x3_edge_clipped_top.
`timescale 1ns / 1ps
`default_nettype none

module bblur_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_operation,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_red,
   input logic [7:0] rsp_out_green,
   input logic [7:0] rsp_out_blue,
   input logic       rsp_last
);
   import bblur_pkg::*;

   // row stores are being cleared right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("req_ready high during clearing pass");

   // an accepted pixel beat always takes the sequencer out of idle in the cycle after
   a_busy_after_pixel: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_operation == OP_PIXEL) |=> !req_ready)
      else $error("req_ready high right after a pixel beat");

   // a new result only leaves the multiply stage, never straight from idle
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("rsp beat appeared without work in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_red)
         && $stable(rsp_out_green) && $stable(rsp_out_blue) && $stable(rsp_last)))
      else $error("stalled rsp beat changed");

endmodule

bind box_blur_3x3_edge_clipped_top bblur_checker u_bblur_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_operation (req_operation),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_red   (rsp_out_red),
   .rsp_out_green (rsp_out_green),
   .rsp_out_blue  (rsp_out_blue),
   .rsp_last      (rsp_last)
);

`default_nettype wire
